// ===== design/es2d_pkg.sv =====
// Package for epoch_seconds_to_date: calendar constants, reciprocal
// constants for the divide-by-constant steps, month start table.
// No dependencies.
package es2d_pkg;

  localparam int unsigned SecsPerMinute = 60;
  localparam int unsigned SecsPerDay    = 86400;
  localparam int unsigned DaysPlainYear = 365;
  localparam int unsigned DaysQuad      = 4 * DaysPlainYear + 1;
  localparam int unsigned YearBeforeBase = 1969;
  localparam logic [31:0] LimitSeconds  = 32'd4102444800;

  // floor(2^40 / 675): (secs >> 7) / 675 == secs / 86400, estimate low by at most 1
  localparam logic [30:0] DayRecip      = 31'd1628906115;
  localparam int unsigned DayRecipShift = 40;
  // ceil(2^27 / 1461): exact for dividends below 94519
  localparam logic [16:0] QuadRecip     = 17'd91868;
  localparam int unsigned QuadRecipShift = 27;
  // ceil(2^19 / 15): exact for dividends below 74898
  localparam logic [15:0] Div15Recip    = 16'd34953;
  localparam int unsigned Div15Shift    = 19;

  // First day of year (0-based) of each month, February per leap flag
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && m >= 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// ===== design/epoch_seconds_to_date.sv =====
// Top level of epoch_seconds_to_date: eight-stage pipeline turning seconds
// since 1970-01-01 into year, month, day, hour, minute. Uses es2d_pkg.
// Strobe: out_valid marks each result as its item leaves the last stage.
// Throughput: one item per cycle; busy is never raised, receiver cannot stall.
// Reset: synchronous active-low rst_n clears all stage valid bits only.
module epoch_seconds_to_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  output logic [11:0] out_year_number,
  output logic [3:0]  out_month_number,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour_of_day,
  output logic [5:0]  out_minute_of_hour,
  output logic        out_out_of_range
);
  import es2d_pkg::*;

  // stage valid bits
  logic [7:0] vld_r, vld_nxt;

  // stage payload registers
  logic [31:0] secs1_r, secs2_r, secs3_r;
  logic        oor2_r, oor3_r, oor4_r, oor5_r, oor6_r, oor7_r;
  logic [15:0] dest2_r, dest3_r, dest2_nxt;
  logic [31:0] prod3_r, prod3_nxt;
  logic [15:0] days4_r, days4_nxt;
  logic [16:0] sod4_r, sod4_nxt;
  logic [15:0] dplus5_r, dplus5_nxt;
  logic [5:0]  quad5_r, quad5_nxt, quad6_r;
  logic [10:0] mod5_r, mod5_nxt, mod6_r;
  logic [10:0] rem6_r, rem6_nxt;
  logic [4:0]  hour6_r, hour6_nxt, hour7_r;
  logic [11:0] year7_r, year7_nxt;
  logic [8:0]  doy7_r, doy7_nxt;
  logic        leap7_r, leap7_nxt;
  logic [5:0]  minute7_r, minute7_nxt;

  // output registers
  logic [11:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic        oor_r;

  // intermediates
  logic [55:0] day_prod;
  logic [31:0] rem_full;
  logic        day_corr;
  logic [32:0] quad_prod;
  logic [30:0] mod_prod;
  logic [15:0] quad_mul;
  logic [24:0] hour_prod;
  logic [1:0]  yr_in;
  logic [3:0]  mon_idx;
  logic [8:0]  mon_base;

  assign busy = 1'b0;

  // valid chain
  always_comb begin
    vld_nxt = {vld_r[6:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 2: range check, day estimate by reciprocal multiply
  always_comb begin
    day_prod  = 56'(secs1_r[31:7]) * 56'(DayRecip);
    dest2_nxt = day_prod[DayRecipShift +: 16];
  end

  // stage 3: back-multiply the estimate
  always_comb begin
    prod3_nxt = 32'(dest2_r) * 32'(SecsPerDay);
  end

  // stage 4: seconds of day, one correction step
  always_comb begin
    rem_full  = secs3_r - prod3_r;
    day_corr  = rem_full >= 32'(SecsPerDay);
    days4_nxt = dest3_r + 16'(day_corr);
    sod4_nxt  = day_corr ? 17'(rem_full - 32'(SecsPerDay)) : rem_full[16:0];
  end

  // stage 5: four-year cycle index and minute of day
  always_comb begin
    dplus5_nxt = days4_r + 16'(DaysPlainYear);
    quad_prod  = 33'(dplus5_nxt) * 33'(QuadRecip);
    quad5_nxt  = quad_prod[QuadRecipShift +: 6];
    mod_prod   = 31'(sod4_r[16:2]) * 31'(Div15Recip);
    mod5_nxt   = mod_prod[Div15Shift +: 11];
  end

  // stage 6: day within the four-year cycle, hour of day
  always_comb begin
    quad_mul  = 16'(quad5_r) * 16'(DaysQuad);
    rem6_nxt  = 11'(dplus5_r - quad_mul);
    hour_prod = 25'(mod5_r[10:2]) * 25'(Div15Recip);
    hour6_nxt = hour_prod[Div15Shift +: 5];
  end

  // stage 7: year within the cycle, day of year, minute
  always_comb begin
    yr_in = 2'(rem6_r >= 11'(DaysPlainYear))
          + 2'(rem6_r >= 11'(2 * DaysPlainYear))
          + 2'(rem6_r >= 11'(3 * DaysPlainYear));
    doy7_nxt    = 9'(rem6_r - 11'(yr_in) * 11'(DaysPlainYear));
    leap7_nxt   = (yr_in == 2'd3);
    year7_nxt   = 12'(YearBeforeBase) + {4'd0, quad6_r, 2'b00} + 12'(yr_in);
    minute7_nxt = 6'(mod6_r - 11'(hour6_r) * 11'(SecsPerMinute));
  end

  // stage 8: month by comparing against month starts, then output mux
  always_comb begin
    mon_idx = '0;
    for (int m = 1; m < 12; m++) begin
      mon_idx = mon_idx + 4'(doy7_r >= month_start(4'(m), leap7_r));
    end
    mon_base = month_start(mon_idx, leap7_r);
    if (oor7_r) begin
      year_nxt   = '0;
      month_nxt  = '0;
      day_nxt    = '0;
      hour_nxt   = '0;
      minute_nxt = '0;
    end else begin
      year_nxt   = year7_r;
      month_nxt  = mon_idx + 4'd1;
      day_nxt    = 5'(doy7_r - mon_base) + 5'd1;
      hour_nxt   = hour7_r;
      minute_nxt = minute7_r;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    secs1_r   <= in_epoch_seconds;
    secs2_r   <= secs1_r;
    oor2_r    <= secs1_r >= LimitSeconds;
    dest2_r   <= dest2_nxt;
    secs3_r   <= secs2_r;
    oor3_r    <= oor2_r;
    dest3_r   <= dest2_r;
    prod3_r   <= prod3_nxt;
    oor4_r    <= oor3_r;
    days4_r   <= days4_nxt;
    sod4_r    <= sod4_nxt;
    oor5_r    <= oor4_r;
    dplus5_r  <= dplus5_nxt;
    quad5_r   <= quad5_nxt;
    mod5_r    <= mod5_nxt;
    oor6_r    <= oor5_r;
    quad6_r   <= quad5_r;
    mod6_r    <= mod5_r;
    rem6_r    <= rem6_nxt;
    hour6_r   <= hour6_nxt;
    oor7_r    <= oor6_r;
    year7_r   <= year7_nxt;
    doy7_r    <= doy7_nxt;
    leap7_r   <= leap7_nxt;
    hour7_r   <= hour6_r;
    minute7_r <= minute7_nxt;
    year_r    <= year_nxt;
    month_r   <= month_nxt;
    day_r     <= day_nxt;
    hour_r    <= hour_nxt;
    minute_r  <= minute_nxt;
    oor_r     <= oor7_r;
  end

  assign out_valid          = vld_r[7];
  assign out_year_number    = year_r;
  assign out_month_number   = month_r;
  assign out_day_of_month   = day_r;
  assign out_hour_of_day    = hour_r;
  assign out_minute_of_hour = minute_r;
  assign out_out_of_range   = oor_r;

  // every result comes from an earlier input transfer
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 8))
    else $error("result without matching input transfer");

  // every transfer yields a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##8 out_valid)
    else $error("input transfer lost in pipeline");

  // in-range results carry legal calendar fields
  a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_of_range) |->
      (out_year_number >= 12'd1970 && out_year_number <= 12'd2099 &&
       out_month_number >= 4'd1 && out_month_number <= 4'd12 &&
       out_day_of_month >= 5'd1 && out_hour_of_day <= 5'd23 &&
       out_minute_of_hour <= 6'd59))
    else $error("calendar field out of bounds");

endmodule

// ===== sim/tb_epoch_seconds_to_date.sv =====
// Testbench for epoch_seconds_to_date: drives second counts, predicts the
// calendar date per transfer and checks every strobed result in order.
// Depends on the design top level only (the block needs es2d_pkg compiled).
module tb_epoch_seconds_to_date;

  localparam logic [31:0] FirstOutOfRange = 32'd4102444800;
  localparam int unsigned SecondsPerDay  = 86400;
  localparam int unsigned LastValidDay   = 47481;
  localparam int unsigned RandomPerPhase = 320;
  localparam int unsigned DrainGuard     = 2000;

  // One result as the block presents it
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        beyond;
  } date_t;

  // Expected-date store and checker
  class date_scoreboard;
    date_t       expected_dates[$];
    logic [31:0] request_secs[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Calendar date of a second count, hours 0 to 23, seconds dropped
    function automatic date_t calendar_of(logic [31:0] secs);
      date_t       d;
      int unsigned rest;
      int unsigned yr;
      int unsigned yday;
      int unsigned mon;
      int unsigned span;
      logic        leap;
      d = '0;
      if (secs >= FirstOutOfRange) begin
        d.beyond = 1'b1;
        return d;
      end
      rest = secs;
      yr = 1970;
      // walk whole years; every fourth year is a leap year in this span
      forever begin
        span = ((yr % 4) == 0) ? 366 * SecondsPerDay : 365 * SecondsPerDay;
        if (rest < span) break;
        rest -= span;
        yr++;
      end
      leap = (yr % 4) == 0;
      yday = rest / SecondsPerDay;
      rest = rest % SecondsPerDay;
      d.hour   = 5'(rest / 3600);
      d.minute = 6'((rest % 3600) / 60);
      // walk month lengths, December takes whatever is left
      mon = 0;
      while (mon < 11) begin
        case (mon)
          1: begin
            span = leap ? 29 : 28;
          end
          3, 5, 8, 10: begin
            span = 30;
          end
          default: begin
            span = 31;
          end
        endcase
        if (yday < span) break;
        yday -= span;
        mon++;
      end
      d.year  = 12'(yr);
      d.month = 4'(mon + 1);
      d.mday  = 5'(yday + 1);
      return d;
    endfunction

    function void note_request(logic [31:0] secs);
      expected_dates.push_back(calendar_of(secs));
      request_secs.push_back(secs);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_result(date_t got);
      date_t       want;
      logic [31:0] secs;
      if (expected_dates.size() == 0) begin
        report($sformatf("unexpected result y=%0d m=%0d d=%0d %0d:%0d oor=%0d",
                         got.year, got.month, got.mday, got.hour, got.minute,
                         got.beyond));
        return;
      end
      want = expected_dates.pop_front();
      secs = request_secs.pop_front();
      if (got.year !== want.year || got.month !== want.month ||
          got.mday !== want.mday || got.hour !== want.hour ||
          got.minute !== want.minute || got.beyond !== want.beyond) begin
        report($sformatf("secs=%0d expected %0d-%0d-%0d %0d:%0d oor=%0d, got %0d-%0d-%0d %0d:%0d oor=%0d",
                         secs, want.year, want.month, want.mday, want.hour,
                         want.minute, want.beyond, got.year, got.month,
                         got.mday, got.hour, got.minute, got.beyond));
      end
    endfunction

    function int unsigned pending();
      return expected_dates.size();
    endfunction

    // Anything still waiting at the end is a failure
    function void close();
      while (expected_dates.size() != 0) begin
        report($sformatf("no result for secs=%0d", request_secs[0]));
        void'(expected_dates.pop_front());
        void'(request_secs.pop_front());
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_epoch_seconds;
  logic        out_valid;
  logic [11:0] out_year_number;
  logic [3:0]  out_month_number;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour_of_day;
  logic [5:0]  out_minute_of_hour;
  logic        out_out_of_range;

  date_scoreboard sb;

  epoch_seconds_to_date uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_epoch_seconds   (in_epoch_seconds),
    .out_valid          (out_valid),
    .out_year_number    (out_year_number),
    .out_month_number   (out_month_number),
    .out_day_of_month   (out_day_of_month),
    .out_hour_of_day    (out_hour_of_day),
    .out_minute_of_hour (out_minute_of_hour),
    .out_out_of_range   (out_out_of_range)
  );

  // 20-unit clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watch both channels at each edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sb.note_request(in_epoch_seconds);
    end
    if (rst_n && out_valid === 1'b1) begin
      sb.check_result({out_year_number, out_month_number, out_day_of_month,
                       out_hour_of_day, out_minute_of_hour, out_out_of_range});
    end
  end

  // One transfer, after a random idle gap
  task automatic send_seconds(input logic [31:0] secs, input int unsigned idle_pct);
    logic stalled;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_epoch_seconds <= secs;
    // busy only moves at rising edges, so its value at the falling edge
    // decides the next one
    do begin
      @(negedge clk);
      stalled = busy;
      @(posedge clk);
    end while (stalled);
  endtask

  // Hold off until every expected date has come back
  task automatic drain();
    int unsigned guard;
    guard = 0;
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0 && guard < DrainGuard) begin
      @(negedge clk);
      guard++;
    end
    @(posedge clk);
  endtask

  // Random second count, weighted toward day, year and range edges
  function automatic logic [31:0] pick_seconds();
    int unsigned sel;
    int unsigned yr;
    logic [31:0] base;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: begin
        pick_seconds = $urandom();
      end
      2, 3, 4: begin
        base = 32'($urandom_range(0, LastValidDay)) * SecondsPerDay;
        case ($urandom_range(0, 5))
          0: pick_seconds = base;
          1: pick_seconds = base + 32'd1;
          2: pick_seconds = base + 32'd59;
          3: pick_seconds = base + 32'd3600;
          4: pick_seconds = base + 32'd86399;
          default: pick_seconds = base + 32'($urandom_range(0, 86399));
        endcase
      end
      5: begin
        pick_seconds = FirstOutOfRange - 32'd256 + 32'($urandom_range(0, 511));
      end
      6, 7: begin
        // around a New Year midnight
        yr = $urandom_range(1971, 2099);
        base = 32'((yr - 1970) * 365 + (yr - 1969) / 4) * SecondsPerDay;
        pick_seconds = base + 32'($urandom_range(0, 7)) - 32'd4;
      end
      default: begin
        pick_seconds = $urandom_range(0, FirstOutOfRange - 1);
      end
    endcase
  endfunction

  logic [31:0] directed_secs[$] = '{
    32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd31535999, 32'd31536000, 32'd68169599, 32'd68169600, 32'd68255999,
    32'd68256000, 32'd94694399, 32'd94694400, 32'd946684799, 32'd951782400,
    32'd2147483647, 32'd2147483648, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd4102358400, 32'd4102444799, 32'd4102444800, 32'd4102444801,
    32'hFFFF_FFFF
  };

  int unsigned idle_phases[4] = '{0, 77, 17, 0};

  // Main sequence
  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_epoch_seconds = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed edges, back to back
    foreach (directed_secs[i]) begin
      send_seconds(directed_secs[i], 0);
    end
    drain();

    // random phases, with the sender gaps taken from idle_phases
    foreach (idle_phases[p]) begin
      for (int unsigned n = 0; n < RandomPerPhase; n++) begin
        send_seconds(pick_seconds(), idle_phases[p]);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    sb.close();
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
